// ===== hdl/one_wire_bus_master_assert.svh =====
// Assertion macros for the 1-Wire bus master
`ifndef ONE_WIRE_BUS_MASTER_ASSERT_SVH
`define ONE_WIRE_BUS_MASTER_ASSERT_SVH

// Combinational check, sampled on every clock edge out of reset
`define OWBM_ASSERT_NOW(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Implication check between an antecedent and a consequent in the same cycle
`define OWBM_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ===== hdl/owbm_pkg.sv =====
// Types and constants shared by the 1-Wire bus master modules
`timescale 1ns / 1ps

package owbm_pkg;

  localparam int unsigned BITS_PER_BYTE = 8;
  localparam int unsigned CNT_W = 12;
  localparam int unsigned BITS_W = 4;

  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_RESET = 2'd1;
  localparam logic [1:0] REQ_WRITE = 2'd2;
  localparam logic [1:0] REQ_READ  = 2'd3;

  localparam logic [2:0] CFG_RESET_LOW  = 3'd0;
  localparam logic [2:0] CFG_PRES_SMPL  = 3'd1;
  localparam logic [2:0] CFG_RESET_REC  = 3'd2;
  localparam logic [2:0] CFG_W1_LOW     = 3'd3;
  localparam logic [2:0] CFG_W0_LOW     = 3'd4;
  localparam logic [2:0] CFG_SLOT_LEN   = 3'd5;
  localparam logic [2:0] CFG_READ_LOW   = 3'd6;
  localparam logic [2:0] CFG_READ_DLY   = 3'd7;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_RST_LOW   = 3'd1,
    PH_RST_WAIT  = 3'd2,
    PH_RST_REC   = 3'd3,
    PH_SLOT_LOW  = 3'd4,
    PH_SLOT_REL  = 3'd5,
    PH_READ_REST = 3'd6
  } phase_t;

  typedef struct packed {
    logic [9:0] reset_low_time;
    logic [9:0] presence_sample_time;
    logic [9:0] reset_recovery_time;
    logic [7:0] write_one_low_time;
    logic [7:0] write_zero_low_time;
    logic [7:0] slot_length;
    logic [7:0] read_low_time;
    logic [7:0] read_sample_delay;
  } cfg_t;

  typedef struct packed {
    phase_t              phase;
    logic [CNT_W-1:0]    time_count;
    logic [BITS_W-1:0]   bits_left;
    logic [7:0]          shift_byte;
    logic [1:0]          operation;
    logic                presence_flag;
    logic [7:0]          read_result;
  } state_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] data_byte;
    logic       line_level;
  } item_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic       no_presence;
    logic [7:0] read_data;
    logic       rejected;
  } result_t;

endpackage

// ===== hdl/owbm_cfg.sv =====
// Timing configuration registers of the 1-Wire bus master
`timescale 1ns / 1ps

module owbm_cfg
  import owbm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [9:0] cfg_wdata,
  output cfg_t       cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.reset_low_time       <= 10'd480;
      cfg_r.presence_sample_time <= 10'd70;
      cfg_r.reset_recovery_time  <= 10'd410;
      cfg_r.write_one_low_time   <= 8'd6;
      cfg_r.write_zero_low_time  <= 8'd60;
      cfg_r.slot_length          <= 8'd70;
      cfg_r.read_low_time        <= 8'd6;
      cfg_r.read_sample_delay    <= 8'd9;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RESET_LOW: cfg_r.reset_low_time       <= cfg_wdata;
        CFG_PRES_SMPL: cfg_r.presence_sample_time <= cfg_wdata;
        CFG_RESET_REC: cfg_r.reset_recovery_time  <= cfg_wdata;
        CFG_W1_LOW:    cfg_r.write_one_low_time   <= cfg_wdata[7:0];
        CFG_W0_LOW:    cfg_r.write_zero_low_time  <= cfg_wdata[7:0];
        CFG_SLOT_LEN:  cfg_r.slot_length          <= cfg_wdata[7:0];
        CFG_READ_LOW:  cfg_r.read_low_time        <= cfg_wdata[7:0];
        CFG_READ_DLY:  cfg_r.read_sample_delay    <= cfg_wdata[7:0];
        default:       cfg_r <= cfg_r;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== hdl/owbm_step.sv =====
// Next-state and result logic for one word of the 1-Wire bus master
`timescale 1ns / 1ps

module owbm_step
  import owbm_pkg::*;
(
  input  cfg_t    cfg,
  input  state_t  st,
  input  item_t   item,
  output state_t  st_nxt,
  output result_t res
);

  logic [CNT_W-1:0]  tc_inc;
  logic [7:0]        low_len;
  logic [8:0]        rd_thr;
  logic [BITS_W-1:0] bits_dec;
  logic              done;
  logic              rej;
  logic              ge_slot;

  always_comb begin
    st_nxt   = st;
    done     = 1'b0;
    rej      = 1'b0;
    tc_inc   = (st.time_count != {CNT_W{1'b1}}) ? st.time_count + 1'b1 : st.time_count;
    low_len  = (st.operation == REQ_READ) ? cfg.read_low_time :
               (st.shift_byte[0] ? cfg.write_one_low_time : cfg.write_zero_low_time);
    rd_thr   = {1'b0, cfg.read_low_time} + {1'b0, cfg.read_sample_delay};
    bits_dec = st.bits_left - 1'b1;
    ge_slot  = tc_inc >= {{(CNT_W-8){1'b0}}, cfg.slot_length};

    if (item.req_type == REQ_TICK) begin
      if (st.phase != PH_IDLE) begin
        st_nxt.time_count = tc_inc;
        case (st.phase)
          PH_RST_LOW: begin
            if (tc_inc >= {{(CNT_W-10){1'b0}}, cfg.reset_low_time}) begin
              st_nxt.phase      = PH_RST_WAIT;
              st_nxt.time_count = '0;
            end
          end
          PH_RST_WAIT: begin
            if (tc_inc >= {{(CNT_W-10){1'b0}}, cfg.presence_sample_time}) begin
              st_nxt.presence_flag = item.line_level;
              st_nxt.phase         = PH_RST_REC;
              st_nxt.time_count    = '0;
            end
          end
          PH_RST_REC: begin
            if (tc_inc >= {{(CNT_W-10){1'b0}}, cfg.reset_recovery_time}) begin
              st_nxt.phase      = PH_IDLE;
              st_nxt.time_count = '0;
              done              = 1'b1;
            end
          end
          PH_SLOT_LOW: begin
            if (tc_inc >= {{(CNT_W-8){1'b0}}, low_len}) st_nxt.phase = PH_SLOT_REL;
          end
          PH_SLOT_REL, PH_READ_REST: begin
            if (st.phase == PH_SLOT_REL && st.operation == REQ_READ) begin
              if (tc_inc >= {{(CNT_W-9){1'b0}}, rd_thr}) begin
                st_nxt.shift_byte = {item.line_level, st.shift_byte[7:1]};
                st_nxt.phase      = PH_READ_REST;
              end
            end else if (ge_slot) begin
              if (st.operation == REQ_WRITE) st_nxt.shift_byte = {1'b0, st.shift_byte[7:1]};
              st_nxt.bits_left  = bits_dec;
              st_nxt.time_count = '0;
              if (bits_dec == '0) begin
                if (st.operation == REQ_READ) st_nxt.read_result = st.shift_byte;
                st_nxt.phase = PH_IDLE;
                done         = 1'b1;
              end else begin
                st_nxt.phase = PH_SLOT_LOW;
              end
            end
          end
          default: begin
            st_nxt.phase      = PH_IDLE;
            st_nxt.time_count = '0;
          end
        endcase
      end
    end else if (st.phase != PH_IDLE) begin
      rej = 1'b1;
    end else begin
      st_nxt.operation  = item.req_type;
      st_nxt.time_count = '0;
      if (item.req_type == REQ_RESET) begin
        st_nxt.phase = PH_RST_LOW;
      end else begin
        st_nxt.shift_byte = (item.req_type == REQ_WRITE) ? item.data_byte : 8'd0;
        st_nxt.bits_left  = BITS_W'(BITS_PER_BYTE);
        st_nxt.phase      = PH_SLOT_LOW;
      end
    end

    res.drive_low   = (st_nxt.phase == PH_RST_LOW) || (st_nxt.phase == PH_SLOT_LOW);
    res.busy_res    = st_nxt.phase != PH_IDLE;
    res.done_res    = done;
    res.no_presence = st_nxt.presence_flag;
    res.read_data   = st_nxt.read_result;
    res.rejected    = rej;
  end

endmodule

// ===== hdl/one_wire_bus_master.sv =====
// 1-Wire bus master: timing sequencer driven by microsecond tick words
// Path: an accepted input word is held in the input register, then its result word
// is registered in the result register; the state updates as a word moves on.
// Throughput: one word per cycle; a full result register stalls only on out_ready.
// Reset (rst_n low, synchronous): sequencer idle, counters and data cleared,
// timing registers back to 480/70/410/6/60/70/6/9 us, both stages empty.
`timescale 1ns / 1ps
`include "one_wire_bus_master_assert.svh"

module one_wire_bus_master
  import owbm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_req_type,
  input  logic [7:0] in_data_byte,
  input  logic       in_line_level,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_drive_low,
  output logic       out_busy_res,
  output logic       out_done_res,
  output logic       out_no_presence,
  output logic [7:0] out_read_data,
  output logic       out_rejected,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [9:0] cfg_wdata
);

  cfg_t    cfg;
  state_t  state_r;
  state_t  state_nxt;
  item_t   item_r;
  result_t res_nxt;
  result_t res_r;
  logic    item_vld_r;
  logic    res_vld_r;
  logic    adv;

  owbm_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  owbm_step u_step (
    .cfg    (cfg),
    .st     (state_r),
    .item   (item_r),
    .st_nxt (state_nxt),
    .res    (res_nxt)
  );

  assign adv      = item_vld_r && (!res_vld_r || out_ready);
  assign in_ready = !item_vld_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (in_ready) begin
      item_vld_r <= in_valid;
    end
    if (in_valid && in_ready) begin
      item_r.req_type   <= in_req_type;
      item_r.data_byte  <= in_data_byte;
      item_r.line_level <= in_line_level;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase         <= PH_IDLE;
      state_r.time_count    <= '0;
      state_r.bits_left     <= '0;
      state_r.shift_byte    <= '0;
      state_r.operation     <= '0;
      state_r.presence_flag <= 1'b0;
      state_r.read_result   <= '0;
    end else if (adv) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
    end else if (adv) begin
      res_vld_r <= 1'b1;
    end else if (out_ready) begin
      res_vld_r <= 1'b0;
    end
    if (adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid       = res_vld_r;
  assign out_drive_low   = res_r.drive_low;
  assign out_busy_res    = res_r.busy_res;
  assign out_done_res    = res_r.done_res;
  assign out_no_presence = res_r.no_presence;
  assign out_read_data   = res_r.read_data;
  assign out_rejected    = res_r.rejected;

  `OWBM_ASSERT_IMPL(a_idle_count_zero, state_r.phase == PH_IDLE, state_r.time_count == '0, "idle with nonzero count")
  `OWBM_ASSERT_IMPL(a_done_not_busy, out_valid && out_done_res, !out_busy_res && !out_rejected, "done while busy or rejected")
  `OWBM_ASSERT_IMPL(a_drive_busy, out_valid && out_drive_low, out_busy_res, "line driven while idle")
  `OWBM_ASSERT_NOW(a_bits_range, state_r.bits_left <= BITS_W'(BITS_PER_BYTE), "bit count out of range")

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for one_wire_bus_master: random tick/command traffic vs a predictor
`timescale 1ns / 1ps

module testbench;
  import owbm_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int HOLD_CYCLES = 300;

  typedef enum {LINE_LOW, LINE_HIGH, LINE_NOISY} line_pick_t;
  typedef enum {RX_OPEN, RX_MOSTLY, RX_PATTERN, RX_SPARSE} rx_mode_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] in_req_type = REQ_TICK;
  logic [7:0] in_data_byte = 8'h00;
  logic       in_line_level = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       out_drive_low;
  logic       out_busy_res;
  logic       out_done_res;
  logic       out_no_presence;
  logic [7:0] out_read_data;
  logic       out_rejected;
  logic       cfg_we = 1'b0;
  logic [2:0] cfg_index = CFG_RESET_LOW;
  logic [9:0] cfg_wdata = 10'd0;

  one_wire_bus_master uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_req_type(in_req_type), .in_data_byte(in_data_byte), .in_line_level(in_line_level),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_drive_low(out_drive_low), .out_busy_res(out_busy_res), .out_done_res(out_done_res),
    .out_no_presence(out_no_presence), .out_read_data(out_read_data),
    .out_rejected(out_rejected),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #4 clk = ~clk;

  // bus sequencer shadow
  cfg_t         timing = '{10'd480, 10'd70, 10'd410, 8'd6, 8'd60, 8'd70, 8'd6, 8'd9};
  phase_t       seq_phase = PH_IDLE;
  logic [11:0]  tcount = '0;
  logic [3:0]   bits_left = '0;
  logic [7:0]   shreg = '0;
  logic [1:0]   cur_op = '0;
  logic         pres_flag = 1'b0;
  logic [7:0]   rd_byte = '0;

  item_t   word_q[$];
  result_t status_q[$];
  item_t   next_word;
  item_t   taken;
  result_t want;
  int      words_queued = 0;
  int      results_seen = 0;
  int      mismatches = 0;
  int      cycle_count = 0;
  int      burst_left = 0;
  int      gap_left = 0;
  int      hold_requests = 0;
  int      holds_done = 0;
  int      hold_left = 0;
  int      mode_left = 0;
  int      beat = 0;
  rx_mode_t stall_mode = RX_OPEN;

  function automatic logic slot_finish();
    if (cur_op == REQ_WRITE) shreg = shreg >> 1;
    bits_left = bits_left - 4'd1;
    tcount = '0;
    if (bits_left == 4'd0) begin
      if (cur_op == REQ_READ) rd_byte = shreg;
      seq_phase = PH_IDLE;
      return 1'b1;
    end
    seq_phase = PH_SLOT_LOW;
    return 1'b0;
  endfunction

  function automatic logic advance_us(logic lvl);
    int low;
    if (seq_phase == PH_IDLE) return 1'b0;
    if (tcount < 12'hFFF) tcount = tcount + 12'd1;
    case (seq_phase)
      PH_RST_LOW: if (tcount >= timing.reset_low_time) begin
        seq_phase = PH_RST_WAIT;
        tcount = '0;
      end
      PH_RST_WAIT: if (tcount >= timing.presence_sample_time) begin
        pres_flag = lvl;
        seq_phase = PH_RST_REC;
        tcount = '0;
      end
      PH_RST_REC: if (tcount >= timing.reset_recovery_time) begin
        seq_phase = PH_IDLE;
        tcount = '0;
        return 1'b1;
      end
      PH_SLOT_LOW: begin
        if (cur_op == REQ_READ) low = int'(timing.read_low_time);
        else low = shreg[0] ? int'(timing.write_one_low_time) :
                              int'(timing.write_zero_low_time);
        if (int'(tcount) >= low) seq_phase = PH_SLOT_REL;
      end
      PH_SLOT_REL: begin
        if (cur_op == REQ_READ) begin
          if (int'(tcount) >= int'(timing.read_low_time) + int'(timing.read_sample_delay)) begin
            shreg = {lvl, shreg[7:1]};
            seq_phase = PH_READ_REST;
          end
        end else if (tcount >= timing.slot_length) begin
          return slot_finish();
        end
      end
      PH_READ_REST: if (tcount >= timing.slot_length) return slot_finish();
      default: begin
        seq_phase = PH_IDLE;
        tcount = '0;
      end
    endcase
    return 1'b0;
  endfunction

  function automatic result_t predict_status(item_t it);
    result_t r;
    logic fin, rej;
    fin = 1'b0;
    rej = 1'b0;
    if (it.req_type == REQ_TICK) begin
      fin = advance_us(it.line_level);
    end else if (seq_phase != PH_IDLE) begin
      rej = 1'b1;
    end else begin
      cur_op = it.req_type;
      tcount = '0;
      if (it.req_type == REQ_RESET) begin
        seq_phase = PH_RST_LOW;
      end else begin
        shreg = (it.req_type == REQ_WRITE) ? it.data_byte : 8'h00;
        bits_left = 4'(BITS_PER_BYTE);
        seq_phase = PH_SLOT_LOW;
      end
    end
    r.drive_low = (seq_phase == PH_RST_LOW) || (seq_phase == PH_SLOT_LOW);
    r.busy_res = (seq_phase != PH_IDLE);
    r.done_res = fin;
    r.no_presence = pres_flag;
    r.read_data = rd_byte;
    r.rejected = rej;
    return r;
  endfunction

  // sender: bursts with random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        taken = {in_req_type, in_data_byte, in_line_level};
        status_q.push_back(predict_status(taken));
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0 || word_q.size() == 0) begin
          if (gap_left > 0) gap_left--;
          in_valid <= 1'b0;
        end else begin
          next_word = word_q.pop_front();
          in_valid <= 1'b1;
          in_req_type <= next_word.req_type;
          in_data_byte <= next_word.data_byte;
          in_line_level <= next_word.line_level;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
  end

  // receiver: stall modes plus requested long hold-offs
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      beat++;
      if (mode_left == 0) begin
        stall_mode = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(64, 256);
      end else begin
        mode_left--;
      end
      if (holds_done != hold_requests) begin
        holds_done++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (stall_mode)
          RX_OPEN: out_ready <= 1'b1;
          RX_MOSTLY: out_ready <= ($urandom_range(0, 3) != 0);
          RX_PATTERN: out_ready <= ((beat % 5) < 3);
          default: out_ready <= ($urandom_range(0, 4) < 2);
        endcase
      end
    end
  end

  task automatic flag_field(string field, logic [7:0] exp_v, logic [7:0] got_v);
    mismatches++;
    $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, exp_v, got_v);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (status_q.size() == 0) begin
        mismatches++;
        $display("%0t: result word with nothing expected", $time);
      end else begin
        want = status_q.pop_front();
        if (want.drive_low !== out_drive_low)
          flag_field("drive_low", 8'(want.drive_low), 8'(out_drive_low));
        if (want.busy_res !== out_busy_res)
          flag_field("busy_res", 8'(want.busy_res), 8'(out_busy_res));
        if (want.done_res !== out_done_res)
          flag_field("done_res", 8'(want.done_res), 8'(out_done_res));
        if (want.no_presence !== out_no_presence)
          flag_field("no_presence", 8'(want.no_presence), 8'(out_no_presence));
        if (want.read_data !== out_read_data)
          flag_field("read_data", want.read_data, out_read_data);
        if (want.rejected !== out_rejected)
          flag_field("rejected", 8'(want.rejected), 8'(out_rejected));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic push_word(logic [1:0] req, logic [7:0] data, logic lvl);
    item_t w;
    w.req_type = req;
    w.data_byte = data;
    w.line_level = lvl;
    word_q.push_back(w);
    words_queued++;
  endtask

  function automatic int at_least_one(int v);
    return (v < 1) ? 1 : v;
  endfunction

  // upper bound on ticks until a command completes under the current timing
  function automatic int command_ticks(logic [1:0] req);
    int lo, smp, slot;
    slot = int'(timing.slot_length);
    case (req)
      REQ_RESET: return at_least_one(int'(timing.reset_low_time)) +
                        at_least_one(int'(timing.presence_sample_time)) +
                        at_least_one(int'(timing.reset_recovery_time));
      REQ_WRITE: begin
        lo = at_least_one(int'((timing.write_zero_low_time > timing.write_one_low_time) ?
                               timing.write_zero_low_time : timing.write_one_low_time));
        return int'(BITS_PER_BYTE) * ((slot > lo) ? slot : lo + 1);
      end
      default: begin
        lo = at_least_one(int'(timing.read_low_time));
        smp = int'(timing.read_low_time) + int'(timing.read_sample_delay);
        if (smp < lo + 1) smp = lo + 1;
        return int'(BITS_PER_BYTE) * ((slot > smp) ? slot : smp + 1);
      end
    endcase
  endfunction

  task automatic run_command(logic [1:0] req, logic [7:0] data, line_pick_t pick, int slack,
                             bit with_rejects);
    int n;
    logic lvl;
    n = command_ticks(req) + slack;
    push_word(req, data, 1'($urandom_range(0, 1)));
    for (int i = 0; i < n; i++) begin
      case (pick)
        LINE_LOW: lvl = 1'b0;
        LINE_HIGH: lvl = 1'b1;
        default: lvl = 1'($urandom_range(0, 1));
      endcase
      if (with_rejects && $urandom_range(0, 19) == 0)
        push_word(2'($urandom_range(1, 3)), 8'($urandom), lvl);
      else
        push_word(REQ_TICK, 8'($urandom), lvl);
    end
  endtask

  task automatic drain();
    while (results_seen != words_queued) @(posedge clk);
  endtask

  task automatic settle();
    drain();
    while (seq_phase != PH_IDLE) begin
      repeat (16) push_word(REQ_TICK, 8'($urandom), 1'($urandom_range(0, 1)));
      drain();
    end
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [9:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_RESET_LOW: timing.reset_low_time = val;
      CFG_PRES_SMPL: timing.presence_sample_time = val;
      CFG_RESET_REC: timing.reset_recovery_time = val;
      CFG_W1_LOW: timing.write_one_low_time = val[7:0];
      CFG_W0_LOW: timing.write_zero_low_time = val[7:0];
      CFG_SLOT_LEN: timing.slot_length = val[7:0];
      CFG_READ_LOW: timing.read_low_time = val[7:0];
      default: timing.read_sample_delay = val[7:0];
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_timing(int rl, int ps, int rr, int w1, int w0, int sl, int rlo, int rd);
    write_reg(CFG_RESET_LOW, 10'(rl));
    write_reg(CFG_PRES_SMPL, 10'(ps));
    write_reg(CFG_RESET_REC, 10'(rr));
    write_reg(CFG_W1_LOW, 10'(w1));
    write_reg(CFG_W0_LOW, 10'(w0));
    write_reg(CFG_SLOT_LEN, 10'(sl));
    write_reg(CFG_READ_LOW, 10'(rlo));
    write_reg(CFG_READ_DLY, 10'(rd));
  endtask

  // short times, now and then zero, narrow ones sometimes with bits above their width
  function automatic int short_time(bit narrow, int hi);
    int pick;
    pick = $urandom_range(0, 7);
    if (pick == 0) return 0;
    if (pick == 1 && narrow) return 10'h300 | $urandom_range(1, hi);
    return $urandom_range(1, hi);
  endfunction

  task automatic random_traffic(int target);
    int stop, slack;
    stop = words_queued + target;
    while (words_queued < stop) begin
      if ($urandom_range(0, 9) < 8) begin
        slack = $urandom_range(0, 7);
        run_command(2'($urandom_range(1, 3)), 8'($urandom),
                    line_pick_t'($urandom_range(0, 2)), slack - 3, 1'b1);
      end else begin
        repeat ($urandom_range(1, 8))
          push_word(2'($urandom_range(0, 3)), 8'($urandom), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // power-up timing: first slots of a write, then timing shortened mid-command
    push_word(REQ_TICK, 8'h00, 1'b0);
    push_word(REQ_TICK, 8'hFF, 1'b1);
    push_word(REQ_WRITE, 8'hA5, 1'b1);
    repeat (100) push_word(REQ_TICK, 8'h00, 1'b1);
    drain();

    // shortest legal timing, busy commands of every kind
    load_timing(1, 1, 1, 1, 1, 2, 1, 1);
    settle();
    push_word(REQ_RESET, 8'h00, 1'b1);
    push_word(REQ_WRITE, 8'h3C, 1'b0);
    push_word(REQ_READ, 8'h00, 1'b1);
    push_word(REQ_RESET, 8'h00, 1'b0);
    repeat (command_ticks(REQ_RESET)) push_word(REQ_TICK, 8'h00, 1'b0);
    push_word(REQ_TICK, 8'h00, 1'b1);
    run_command(REQ_RESET, 8'h00, LINE_HIGH, 0, 1'b0);
    run_command(REQ_WRITE, 8'hFF, LINE_NOISY, 0, 1'b0);
    run_command(REQ_WRITE, 8'h00, LINE_NOISY, 0, 1'b0);
    run_command(REQ_READ, 8'h00, LINE_HIGH, 0, 1'b0);
    run_command(REQ_READ, 8'hFF, LINE_LOW, 0, 1'b0);
    settle();

    // zero lengths act as one tick
    load_timing(0, 0, 0, 0, 0, 0, 0, 0);
    run_command(REQ_RESET, 8'h00, LINE_LOW, 0, 1'b0);
    run_command(REQ_WRITE, 8'h96, LINE_NOISY, 0, 1'b0);
    run_command(REQ_READ, 8'h00, LINE_NOISY, 0, 1'b0);
    settle();

    // low time past slot end, read sample past slot end
    load_timing(2, 3, 2, 1, 6, 3, 2, 3);
    run_command(REQ_WRITE, 8'h0F, LINE_NOISY, 0, 1'b0);
    run_command(REQ_READ, 8'h00, LINE_NOISY, 0, 1'b0);
    settle();

    for (int k = 0; k < 4; k++) begin
      load_timing(short_time(1'b0, 12), short_time(1'b0, 12), short_time(1'b0, 12),
                  short_time(1'b1, 10), short_time(1'b1, 16), short_time(1'b1, 16),
                  short_time(1'b1, 8), short_time(1'b1, 10));
      if (k == 1) hold_requests++;
      random_traffic(60);
      settle();
    end

    // widest reset timing, cut short by a live rewrite
    load_timing(1023, 1023, 1023, 2, 9, 7, 1, 3);
    push_word(REQ_RESET, 8'h00, 1'b0);
    repeat (260) push_word(REQ_TICK, 8'h00, 1'b0);
    drain();
    load_timing(3, 4, 2, 2, 9, 7, 1, 3);
    settle();

    // wide slot timing with bits above the register width, cut short the same way
    load_timing(3, 4, 2, 1023, 1023, 1023, 200, 1023);
    push_word(REQ_READ, 8'h00, 1'b1);
    repeat (210) push_word(REQ_TICK, 8'($urandom), 1'($urandom_range(0, 1)));
    drain();
    load_timing(3, 4, 2, 2, 5, 8, 2, 3);
    settle();

    drain();
    repeat (10) @(posedge clk);
    if (mismatches == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
